>>> rtl/core/acss_pkg.sv
// Shared types and constants for the converter channel scan sequencer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package acss_pkg;

  localparam int NUM_ENTRIES = 8;
  localparam int ENTRY_W     = 16;
  localparam int IDX_W       = 4;
  localparam int ENTRY_SEL_W = 3;
  localparam int OP_W        = 2;
  localparam int SAMPLE_W    = 10;
  localparam int MUX_W       = 8;
  localparam int SLOT_W      = 6;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 5;
  localparam int DEF_LIST_LENGTH = 8;

  localparam int BIT_END     = 15;
  localparam int BIT_DISCARD = 14;
  localparam int SLOT_LSB    = 8;

  typedef enum logic [OP_W-1:0] {
    OP_START    = 2'd0,
    OP_COMPLETE = 2'd1,
    OP_POLL     = 2'd2
  } op_t;

  typedef logic [NUM_ENTRIES-1:0][ENTRY_W-1:0] entry_array_t;

  typedef struct packed {
    logic                start_convert;
    logic [MUX_W-1:0]    mux_code;
    logic                store_enable;
    logic [SLOT_W-1:0]   store_slot;
    logic [SAMPLE_W-1:0] store_value;
    logic                busy_res;
    logic                scan_done;
  } result_t;

endpackage

>>> rtl/core/acss_regs.sv
// Channel word register file behind the APB-style configuration port.
// Depends on acss_pkg.
`timescale 1ns / 1ps

module acss_regs import acss_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output entry_array_t          entries
);

  logic [ENTRY_SEL_W-1:0] sel;
  logic                   wr;

  assign sel    = paddr[APB_ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign prdata = {{(APB_DATA_W-ENTRY_W){1'b0}}, entries[sel]};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        entries[i] <= ENTRY_W'(1) << BIT_END;
      end
    end else if (wr) begin
      entries[sel] <= pwdata[ENTRY_W-1:0];
    end
  end

endmodule

>>> rtl/core/acss_step.sv
// Scan state (index, running, done reported) and the per-request result logic.
// Depends on acss_pkg.
`timescale 1ns / 1ps

module acss_step import acss_pkg::*; #(
  parameter int LIST_LENGTH = DEF_LIST_LENGTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic [OP_W-1:0]     opcode,
  input  logic [SAMPLE_W-1:0] sample_value,
  input  entry_array_t        entries,
  output result_t             res
);

  logic [IDX_W-1:0] entry_index, entry_index_next;
  logic             scanning, scanning_next;
  logic             done_reported, done_reported_next;

  logic [IDX_W-1:0]   issue_idx;
  logic               do_issue;
  logic [ENTRY_W-1:0] cur_word;
  logic [ENTRY_W-1:0] issue_word;
  logic               issue_ok;

  assign cur_word   = entries[entry_index[ENTRY_SEL_W-1:0]];
  assign issue_word = entries[issue_idx[ENTRY_SEL_W-1:0]];
  assign issue_ok   = (issue_idx < IDX_W'(LIST_LENGTH)) && !issue_word[BIT_END];

  always_comb begin
    entry_index_next   = entry_index;
    scanning_next      = scanning;
    done_reported_next = done_reported;
    issue_idx          = entry_index;
    do_issue           = 1'b0;
    res                = '0;

    unique case (op_t'(opcode))
      OP_START: begin
        issue_idx          = '0;
        entry_index_next   = '0;
        done_reported_next = 1'b0;
        do_issue           = 1'b1;
      end
      OP_COMPLETE: begin
        if (scanning) begin
          if (!cur_word[BIT_DISCARD]) begin
            res.store_enable = 1'b1;
            res.store_slot   = cur_word[SLOT_LSB +: SLOT_W];
            res.store_value  = sample_value;
          end
          issue_idx        = entry_index + IDX_W'(1);
          entry_index_next = issue_idx;
          do_issue         = 1'b1;
        end
      end
      OP_POLL: begin
        if (!scanning && !done_reported) begin
          done_reported_next = 1'b1;
          res.scan_done      = 1'b1;
        end
      end
      default: ;
    endcase

    if (do_issue) begin
      scanning_next = issue_ok;
      if (issue_ok) begin
        res.start_convert = 1'b1;
        res.mux_code      = issue_word[MUX_W-1:0];
      end
    end

    res.busy_res = scanning_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_index   <= '0;
      scanning      <= 1'b0;
      done_reported <= 1'b0;
    end else if (advance) begin
      entry_index   <= entry_index_next;
      scanning      <= scanning_next;
      done_reported <= done_reported_next;
    end
  end

endmodule

>>> rtl/core/adc_channel_scan_sequencer_core.sv
// Top level of the converter channel scan sequencer: request and result registers.
// Depends on acss_pkg, acss_regs and acss_step.
`timescale 1ns / 1ps
//
//  channel   handshake             payload
//  in        in_valid / in_stall   opcode, sample_value
//  out       out_valid / out_stall start_convert .. scan_done
//  cfg       APB psel/penable      paddr, pwdata, prdata
//
//  One request per cycle while the output is not stalled; each result passes through
//  the request register, then the result register, and is set by the scan state update.
//  Synchronous active-high reset restores every channel word to end-of-list.
//  A stalled result holds; one request waits in the request register behind it.

module adc_channel_scan_sequencer_core import acss_pkg::*; #(
  parameter int LIST_LENGTH = DEF_LIST_LENGTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OP_W-1:0]       opcode,
  input  logic [SAMPLE_W-1:0]   sample_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  start_convert,
  output logic [MUX_W-1:0]      mux_code,
  output logic                  store_enable,
  output logic [SLOT_W-1:0]     store_slot,
  output logic [SAMPLE_W-1:0]   store_value,
  output logic                  busy_res,
  output logic                  scan_done,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  entry_array_t        entries;
  logic                req_valid;
  logic [OP_W-1:0]     req_opcode;
  logic [SAMPLE_W-1:0] req_sample;
  logic                out_ready;
  logic                advance;
  result_t             res;
  result_t             res_q;

  assign out_ready = !out_valid || !out_stall;
  assign advance   = req_valid && out_ready;
  assign in_stall  = req_valid && !out_ready;

  acss_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .entries (entries)
  );

  acss_step #(
    .LIST_LENGTH (LIST_LENGTH)
  ) u_step (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .opcode       (req_opcode),
    .sample_value (req_sample),
    .entries      (entries),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!in_stall) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_opcode <= opcode;
      req_sample <= sample_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign start_convert = res_q.start_convert;
  assign mux_code      = res_q.mux_code;
  assign store_enable  = res_q.store_enable;
  assign store_slot    = res_q.store_slot;
  assign store_value   = res_q.store_value;
  assign busy_res      = res_q.busy_res;
  assign scan_done     = res_q.scan_done;

endmodule
